/* rtl/core/pattern_dither_palette_mapper_defines.svh */
// ----------------------------------------------------------------------------
// Pattern dither palette mapper: assertion macros
// Shared helpers for the port checker, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef PATTERN_DITHER_PALETTE_MAPPER_DEFINES_SVH
`define PATTERN_DITHER_PALETTE_MAPPER_DEFINES_SVH

// same-cycle implication
`define PDPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PDPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pdpm_pkg.sv */
// ----------------------------------------------------------------------------
// Pattern dither palette mapper package
// Types, sizes and constant tables shared by the mapper modules.
// ----------------------------------------------------------------------------
package pdpm_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
	localparam int CAND_CNT  = 64;
	localparam int CAND_AW   = $clog2(CAND_CNT);
	localparam int POS_W     = 12;
	localparam int IDX_W     = 8;
	localparam int COL_W     = 24;
	localparam int DIST_W    = 37;
	localparam int LUMA_W    = 18;
	localparam int ATT_RECIP = 5243;
	localparam int ATT_SHIFT = 19;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	localparam logic [0:0] CFG_PAL_LOG2 = 1'b0;
	localparam logic [0:0] CFG_THRESH   = 1'b1;

	localparam logic [3:0] PAL_LOG2_RST = 4'd8;
	localparam logic [6:0] THRESH_RST   = 7'd50;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic signed [8:0] r;
		logic signed [8:0] g;
		logic signed [8:0] b;
	} err_t;

	typedef struct packed {
		logic vld;
		logic last;
		rgb_t pal;
	} dist_in_t;

	typedef struct packed {
		logic              vld;
		logic              last;
		rgb_t              col;
		logic [DIST_W-1:0] dsum;
	} dist_out_t;

	localparam logic [5:0] BAYER [64] = '{
		6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
		6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
		6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
		6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
		6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
		6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
		6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
		6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
	};

endpackage

/* rtl/core/pattern_dither_palette_mapper.sv */
// ----------------------------------------------------------------------------
// Pattern dither palette mapper
// 8x8 pattern dither of pixels onto a palette held in RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): cmd 0 writes palette entry entry_index,
// cmd 1 dithers one pixel. Results leave on out_valid/out_stall, one per
// pixel, none per palette write. Configuration via cfg_we/cfg_index/cfg_data
// while idle.
// A palette write does not make the block busy. A pixel item runs 64
// candidate searches, each reading the P palette entries in use (one
// palette RAM read per cycle through the distance pipeline), then a rank
// pass per candidate tried (one candidate RAM read per cycle) until the
// Bayer rank is hit, and then loads the output register.
// One item is worked on at a time; in_stall is high while a pixel is busy.
// The output register lets the next item be taken while a result waits;
// a stalled result holds, and a finished pixel waits until the register
// is free. Reset clears control state and sets palette_log2 to 8 and
// threshold_percent to 50; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module pattern_dither_palette_mapper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [pdpm_pkg::IDX_W-1:0]    entry_index,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [pdpm_pkg::POS_W-1:0]    column,
	input  logic [pdpm_pkg::POS_W-1:0]    row,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    dithered_red,
	output logic [7:0]                    dithered_green,
	output logic [7:0]                    dithered_blue,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [6:0]                    cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ATT   = 7'b0000010,
		S_SRCH  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_RANK  = 7'b0010000,
		S_RWAIT = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t                         state_q;
	logic [3:0]                     pal_log2_q;
	logic [6:0]                     thr_q;
	pdpm_pkg::rgb_t                 pix_q, best_q, li_col_q, out_q, att;
	pdpm_pkg::err_t                 err_q;
	logic [5:0]                     tgt_q, k_q, i_q;
	logic [1:0]                     ph_q;
	logic [pdpm_pkg::PAL_AW-1:0]    addr_q, last_addr_q, last_addr_c;
	logic                           rv_s1, rl_s1, first_q;
	logic [pdpm_pkg::DIST_W-1:0]    bestd_q;
	logic [6:0]                     sc_q, cnt_q, cnt_c;
	logic                           rk_v_s1, rk_head_s1, rk_last_s1;
	logic                           rk_v_s2, rk_head_s2, rk_last_s2;
	logic [5:0]                     rk_j_s1, rk_j_s2, rk_addr_c;
	logic [pdpm_pkg::LUMA_W-1:0]    luma_s2, li_q;
	pdpm_pkg::rgb_t                 col_s2;
	logic                           out_valid_q;
	logic                           in_acc, pal_we, out_free, take_c, hit_c;
	pdpm_pkg::rgb_t                 nb_c, pal_rd, cand_rd;
	pdpm_pkg::dist_in_t             din;
	pdpm_pkg::dist_out_t            dout;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign pal_we   = in_acc & (cmd == pdpm_pkg::CMD_WRITE)
	                & (32'(entry_index) < pdpm_pkg::PAL_DEPTH);
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		if (pal_log2_q >= 4'(pdpm_pkg::PAL_AW)) begin
			last_addr_c = pdpm_pkg::PAL_AW'(pdpm_pkg::PAL_DEPTH - 1);
		end else begin
			last_addr_c = (pdpm_pkg::PAL_AW'(1) << pal_log2_q) - pdpm_pkg::PAL_AW'(1);
			if (32'(last_addr_c) > pdpm_pkg::PAL_DEPTH - 1) begin
				last_addr_c = pdpm_pkg::PAL_AW'(pdpm_pkg::PAL_DEPTH - 1);
			end
		end
	end

	pdpm_ram #(.WIDTH(pdpm_pkg::COL_W), .DEPTH(pdpm_pkg::PAL_DEPTH)) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (entry_index[pdpm_pkg::PAL_AW-1:0]),
		.wdata ({red, green, blue}),
		.raddr (addr_q),
		.rdata (pal_rd)
	);

	pdpm_att u_att (
		.clk (clk),
		.pix (pix_q),
		.err (err_q),
		.thr (thr_q),
		.att (att)
	);

	assign din.vld  = rv_s1;
	assign din.last = rl_s1;
	assign din.pal  = pal_rd;

	pdpm_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.att    (att),
		.din    (din),
		.dout   (dout)
	);

	assign take_c = first_q | (dout.dsum < bestd_q);
	assign nb_c   = take_c ? dout.col : best_q;

	assign rk_addr_c = (sc_q == 7'd0) ? i_q : 6'(sc_q - 7'd1);

	pdpm_ram #(.WIDTH(pdpm_pkg::COL_W), .DEPTH(pdpm_pkg::CAND_CNT)) u_cand (
		.clk   (clk),
		.we    (dout.vld & dout.last & (state_q == S_DRAIN)),
		.waddr (k_q),
		.wdata (nb_c),
		.raddr (rk_addr_c),
		.rdata (cand_rd)
	);

	assign hit_c = (luma_s2 < li_q) || ((luma_s2 == li_q) && (rk_j_s2 < i_q));
	assign cnt_c = cnt_q + {6'b0, hit_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pal_log2_q  <= pdpm_pkg::PAL_LOG2_RST;
			thr_q       <= pdpm_pkg::THRESH_RST;
			ph_q        <= '0;
			k_q         <= '0;
			i_q         <= '0;
			sc_q        <= '0;
			addr_q      <= '0;
			rv_s1       <= 1'b0;
			rl_s1       <= 1'b0;
			first_q     <= 1'b0;
			rk_v_s1     <= 1'b0;
			rk_v_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pdpm_pkg::CFG_PAL_LOG2: pal_log2_q <= cfg_data[3:0];
					pdpm_pkg::CFG_THRESH:   thr_q      <= cfg_data;
					default: ;
				endcase
			end
			rv_s1   <= (state_q == S_SRCH);
			rl_s1   <= (state_q == S_SRCH) && (addr_q == last_addr_q);
			rk_v_s1 <= (state_q == S_RANK);
			rk_v_s2 <= rk_v_s1;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_ATT && ph_q == 2'd2) begin
				first_q <= 1'b1;
			end else if (dout.vld) begin
				first_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && cmd == pdpm_pkg::CMD_PIXEL) begin
						k_q     <= '0;
						ph_q    <= '0;
						state_q <= S_ATT;
					end
				end
				S_ATT: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd2) begin
						addr_q  <= '0;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					addr_q <= addr_q + pdpm_pkg::PAL_AW'(1);
					if (addr_q == last_addr_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (dout.vld && dout.last) begin
						k_q  <= k_q + 6'd1;
						ph_q <= '0;
						if (k_q == 6'(pdpm_pkg::CAND_CNT - 1)) begin
							i_q     <= '0;
							sc_q    <= '0;
							state_q <= S_RANK;
						end else begin
							state_q <= S_ATT;
						end
					end
				end
				S_RANK: begin
					sc_q <= sc_q + 7'd1;
					if (sc_q == 7'(pdpm_pkg::CAND_CNT)) begin
						state_q <= S_RWAIT;
					end
				end
				S_RWAIT: begin
					if (rk_v_s2 && rk_last_s2) begin
						if (cnt_c == {1'b0, tgt_q}) begin
							state_q <= S_OUT;
						end else begin
							i_q     <= i_q + 6'd1;
							sc_q    <= '0;
							state_q <= S_RANK;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && cmd == pdpm_pkg::CMD_PIXEL) begin
			pix_q <= '{r: red, g: green, b: blue};
			tgt_q <= pdpm_pkg::BAYER[{row[2:0], column[2:0]}];
			err_q <= '0;
		end
		if (state_q == S_ATT && ph_q == 2'd0) begin
			last_addr_q <= last_addr_c;
		end
		if (dout.vld) begin
			best_q  <= nb_c;
			bestd_q <= take_c ? dout.dsum : bestd_q;
			if (dout.last) begin
				err_q.r <= $signed({1'b0, nb_c.r}) - $signed({1'b0, pix_q.r});
				err_q.g <= $signed({1'b0, nb_c.g}) - $signed({1'b0, pix_q.g});
				err_q.b <= $signed({1'b0, nb_c.b}) - $signed({1'b0, pix_q.b});
			end
		end
		rk_head_s1 <= (sc_q == 7'd0);
		rk_last_s1 <= (sc_q == 7'(pdpm_pkg::CAND_CNT));
		rk_j_s1    <= rk_addr_c;
		rk_head_s2 <= rk_head_s1;
		rk_last_s2 <= rk_last_s1;
		rk_j_s2    <= rk_j_s1;
		col_s2     <= cand_rd;
		luma_s2    <= pdpm_pkg::LUMA_W'(cand_rd.r) * pdpm_pkg::LUMA_W'(299)
		            + pdpm_pkg::LUMA_W'(cand_rd.g) * pdpm_pkg::LUMA_W'(587)
		            + pdpm_pkg::LUMA_W'(cand_rd.b) * pdpm_pkg::LUMA_W'(114);
		if (rk_v_s2) begin
			if (rk_head_s2) begin
				li_q     <= luma_s2;
				li_col_q <= col_s2;
				cnt_q    <= '0;
			end else begin
				cnt_q <= cnt_c;
			end
		end
		if (state_q == S_OUT && out_free) begin
			out_q <= li_col_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign dithered_red   = out_q.r;
	assign dithered_green = out_q.g;
	assign dithered_blue  = out_q.b;

endmodule

/* rtl/core/pdpm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pdpm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/pdpm_att.sv */
// ----------------------------------------------------------------------------
// Attempt colour pipeline
// pixel - err*thr/100 per channel, truncated, clipped to 0..255. Three stages.
// ----------------------------------------------------------------------------
module pdpm_att (
	input  logic            clk,
	input  pdpm_pkg::rgb_t  pix,
	input  pdpm_pkg::err_t  err,
	input  logic [6:0]      thr,
	output pdpm_pkg::rgb_t  att
);

	logic signed [16:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic signed [16:0] num_r_s2, num_g_s2, num_b_s2;
	logic signed [16:0] thr_x;

	function automatic logic [7:0] quot(input logic signed [16:0] n);
		logic [28:0] m;
		logic [9:0]  q;
		m = {13'b0, n[15:0]} * 29'(pdpm_pkg::ATT_RECIP);
		q = 10'(m >> pdpm_pkg::ATT_SHIFT);
		if (n <= 17'sd0) begin
			return 8'd0;
		end
		return (q > 10'd255) ? 8'd255 : q[7:0];
	endfunction

	function automatic logic signed [16:0] num(input logic [7:0] p,
	                                           input logic signed [16:0] pr);
		return $signed({9'b0, p}) * 17'sd100 - pr;
	endfunction

	assign thr_x = $signed({10'b0, thr});

	always_ff @(posedge clk) begin
		prod_r_s1 <= 17'(err.r) * thr_x;
		prod_g_s1 <= 17'(err.g) * thr_x;
		prod_b_s1 <= 17'(err.b) * thr_x;
		num_r_s2  <= num(pix.r, prod_r_s1);
		num_g_s2  <= num(pix.g, prod_g_s1);
		num_b_s2  <= num(pix.b, prod_b_s1);
		att.r     <= quot(num_r_s2);
		att.g     <= quot(num_g_s2);
		att.b     <= quot(num_b_s2);
	end

endmodule

/* rtl/core/pdpm_dist.sv */
// ----------------------------------------------------------------------------
// Distance pipeline
// D = 750*(299dr^2+587dg^2+114db^2) + (299dr+587dg+114db)^2, five stages.
// ----------------------------------------------------------------------------
module pdpm_dist (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdpm_pkg::rgb_t       att,
	input  pdpm_pkg::dist_in_t   din,
	output pdpm_pkg::dist_out_t  dout
);

	logic [4:0]                  v_q, l_q;
	pdpm_pkg::rgb_t              col_s1, col_s2, col_s3, col_s4, col_s5;
	logic signed [8:0]           dr_s1, dg_s1, db_s1;
	logic [15:0]                 qr_s2, qg_s2, qb_s2;
	logic signed [18:0]          lr_s2, lg_s2, lb_s2;
	logic [26:0]                 wr_s3, wg_s3, wb_s3;
	logic [18:0]                 sa_s3;
	logic [26:0]                 sq_s4;
	logic [37:0]                 ss_s4;
	logic [pdpm_pkg::DIST_W-1:0] dsum_s5;
	logic signed [17:0]          pr_c, pg_c, pb_c;
	logic signed [19:0]          s_c;

	always_comb begin
		pr_c = dr_s1 * dr_s1;
		pg_c = dg_s1 * dg_s1;
		pb_c = db_s1 * db_s1;
		s_c  = 20'(lr_s2) + 20'(lg_s2) + 20'(lb_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			l_q <= '0;
		end else begin
			v_q <= {v_q[3:0], din.vld};
			l_q <= {l_q[3:0], din.last};
		end
	end

	always_ff @(posedge clk) begin
		dr_s1  <= $signed({1'b0, att.r}) - $signed({1'b0, din.pal.r});
		dg_s1  <= $signed({1'b0, att.g}) - $signed({1'b0, din.pal.g});
		db_s1  <= $signed({1'b0, att.b}) - $signed({1'b0, din.pal.b});
		col_s1 <= din.pal;
		qr_s2  <= pr_c[15:0];
		qg_s2  <= pg_c[15:0];
		qb_s2  <= pb_c[15:0];
		lr_s2  <= 19'(dr_s1) * 19'sd299;
		lg_s2  <= 19'(dg_s1) * 19'sd587;
		lb_s2  <= 19'(db_s1) * 19'sd114;
		col_s2 <= col_s1;
		wr_s3  <= 27'(qr_s2) * 27'd299;
		wg_s3  <= 27'(qg_s2) * 27'd587;
		wb_s3  <= 27'(qb_s2) * 27'd114;
		sa_s3  <= (s_c < 20'sd0) ? 19'(-s_c) : 19'(s_c);
		col_s3 <= col_s2;
		sq_s4  <= wr_s3 + wg_s3 + wb_s3;
		ss_s4  <= {19'b0, sa_s3} * {19'b0, sa_s3};
		col_s4 <= col_s3;
		dsum_s5 <= 37'(sq_s4) * 37'd750 + 37'(ss_s4);
		col_s5  <= col_s4;
	end

	assign dout = '{vld: v_q[4], last: l_q[4], col: col_s5, dsum: dsum_s5};

endmodule

/* rtl/core/pdpm_checker.sv */
// ----------------------------------------------------------------------------
// Pattern dither palette mapper port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "pattern_dither_palette_mapper_defines.svh"

module pdpm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       cmd,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] dithered_red,
	input logic [7:0] dithered_green,
	input logic [7:0] dithered_blue
);

	`PDPM_ASSERT_NXT(a_pix_busy, in_valid && !in_stall && cmd, in_stall, "pixel item not busy")
	`PDPM_ASSERT_NXT(a_wr_free, in_valid && !in_stall && !cmd, !in_stall, "palette write stalled")
	`PDPM_ASSERT_IMP(a_out_rise, $rose(out_valid), $past(in_stall), "result without busy pixel")
	`PDPM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dithered_red) && $stable(dithered_green) && $stable(dithered_blue), "stalled item changed")

endmodule

bind pattern_dither_palette_mapper pdpm_checker u_pdpm_checker (.*);

/* tb/pdpm_checker.sv */
// ----------------------------------------------------------------------------
// Pattern dither palette mapper: channel checker
// Watches the item, result and register ports. It keeps its own palette and
// register copies, works out the dithered colour for each accepted pixel item
// and compares each result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module pdpm_tb_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       cmd,
	input  logic [pdpm_pkg::IDX_W-1:0] entry_index,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic [pdpm_pkg::POS_W-1:0] column,
	input  logic [pdpm_pkg::POS_W-1:0] row,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [7:0]                 dithered_red,
	input  logic [7:0]                 dithered_green,
	input  logic [7:0]                 dithered_blue,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [6:0]                 cfg_data,
	output int                         pending,
	output int                         failures
);
	timeunit 1ns;
	timeprecision 1ps;
	import pdpm_pkg::*;

	rgb_t       palette [PAL_DEPTH];
	logic [3:0] pal_log2;
	logic [6:0] thr_pct;
	rgb_t       colour_q [$];

	function automatic longint attempt_of(int pix, int err, int thr);
		longint num;
		num = longint'(pix) * 100 - longint'(err) * thr;
		if (num <= 0)
			return 0;
		num = num / 100;
		return (num > 255) ? 255 : num;
	endfunction

	function automatic longint colour_distance(longint r, longint g, longint b, rgb_t c);
		longint dr, dg, db, sq, s;
		dr = r - c.r;
		dg = g - c.g;
		db = b - c.b;
		sq = 299 * dr * dr + 587 * dg * dg + 114 * db * db;
		s  = 299 * dr + 587 * dg + 114 * db;
		return 750 * sq + s * s;
	endfunction

	function automatic int luma_of(rgb_t c);
		return 299 * c.r + 587 * c.g + 114 * c.b;
	endfunction

	function automatic rgb_t dither_pixel(rgb_t px, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
		rgb_t   cand [CAND_CNT];
		rgb_t   best;
		int     used, er, eg, eb, target, rank, li;
		longint ar, ag, ab, bd, d;
		used = (pal_log2 > 8) ? 256 : (1 << pal_log2);
		if (used > PAL_DEPTH)
			used = PAL_DEPTH;
		er = 0; eg = 0; eb = 0;
		for (int k = 0; k < CAND_CNT; k++) begin
			ar = attempt_of(px.r, er, thr_pct);
			ag = attempt_of(px.g, eg, thr_pct);
			ab = attempt_of(px.b, eb, thr_pct);
			best = palette[0];
			bd = colour_distance(ar, ag, ab, best);
			for (int n = 1; n < used; n++) begin
				d = colour_distance(ar, ag, ab, palette[n]);
				if (d < bd) begin
					bd = d;
					best = palette[n];
				end
			end
			cand[k] = best;
			er = int'(best.r) - int'(px.r);
			eg = int'(best.g) - int'(px.g);
			eb = int'(best.b) - int'(px.b);
		end
		target = BAYER[x[2:0] + 8 * y[2:0]];
		for (int i = 0; i < CAND_CNT; i++) begin
			li = luma_of(cand[i]);
			rank = 0;
			for (int j = 0; j < CAND_CNT; j++)
				if (luma_of(cand[j]) < li || (luma_of(cand[j]) == li && j < i))
					rank++;
			if (rank == target)
				return cand[i];
		end
		return '0;
	endfunction

	assign pending = colour_q.size();

	initial begin
		failures = 0;
		pal_log2 = PAL_LOG2_RST;
		thr_pct  = THRESH_RST;
	end

	always @(posedge clk) begin
		rgb_t exp_c;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_PAL_LOG2)
					pal_log2 <= cfg_data[3:0];
				else
					thr_pct <= cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_WRITE)
					palette[entry_index] <= '{red, green, blue};
				else
					colour_q = {colour_q, dither_pixel('{red, green, blue}, column, row)};
			end
			if (out_valid && !out_stall) begin
				if (colour_q.size() == 0) begin
					$display("%0t: result with none expected: actual %h %h %h", $time,
						dithered_red, dithered_green, dithered_blue);
					failures++;
				end else begin
					exp_c = colour_q.pop_front();
					if (dithered_red !== exp_c.r) begin
						$display("%0t: red expected %h actual %h", $time, exp_c.r, dithered_red);
						failures++;
					end
					if (dithered_green !== exp_c.g) begin
						$display("%0t: green expected %h actual %h", $time, exp_c.g,
							dithered_green);
						failures++;
					end
					if (dithered_blue !== exp_c.b) begin
						$display("%0t: blue expected %h actual %h", $time, exp_c.b,
							dithered_blue);
						failures++;
					end
				end
			end
		end
	end
endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Pattern dither palette mapper testbench
// Loads the first 32 palette entries, runs directed pixels at the register
// extremes, then random phases of palette writes and pixels with random
// idling on both channels. The checker predicts and compares; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pdpm_pkg::*;

	localparam int   CYCLE_LIMIT = 3000000;
	localparam int   PAL_LOAD    = 32;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             in_valid = 0;
	logic             in_stall;
	logic             cmd = 0;
	logic [IDX_W-1:0] entry_index = 0;
	logic [7:0]       red = 0, green = 0, blue = 0;
	logic [POS_W-1:0] column = 0, row = 0;
	logic             out_valid;
	logic             out_stall = 0;
	logic [7:0]       dithered_red, dithered_green, dithered_blue;
	logic             cfg_we = 0;
	logic [0:0]       cfg_index = 0;
	logic [6:0]       cfg_data = 0;
	int               pending, failures;
	int               cycles = 0;
	int               stall_left = 0, run_left = 0;
	bit               quiet = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	pattern_dither_palette_mapper u_dut (.*);

	pdpm_tb_checker u_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1;
			stall_left--;
		end else if (run_left > 0) begin
			out_stall <= 0;
			run_left--;
		end else begin
			out_stall <= 0;
			if ($urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 12);
			else
				run_left = $urandom_range(1, 30);
		end
	end

	task automatic send(logic c, logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [POS_W-1:0] x, logic [POS_W-1:0] y);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid    <= 1;
		cmd         <= c;
		entry_index <= idx;
		red         <= r;
		green       <= g;
		blue        <= b;
		column      <= x;
		row         <= y;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(logic [6:0] lg, logic [6:0] thr);
		drain();
		cfg_we    <= 1;
		cfg_index <= CFG_PAL_LOG2;
		cfg_data  <= lg;
		@(posedge clk);
		cfg_index <= CFG_THRESH;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic rand_pixel();
		send(CMD_PIXEL, 8'($urandom_range(0, 255)), rand_chan(), rand_chan(), rand_chan(),
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
	endtask

	initial begin
		int n;
		logic [6:0] thr;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(CMD_WRITE, 8'd0, 8'h00, 8'h00, 8'h00, 12'h000, 12'h000);
		send(CMD_WRITE, 8'd1, 8'hff, 8'hff, 8'hff, 12'hfff, 12'hfff);
		for (int i = 2; i < PAL_LOAD; i++)
			send(CMD_WRITE, 8'(i), rand_chan(), rand_chan(), rand_chan(),
				12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));

		// threshold at its reset value, 32 entries
		set_regs(7'd5, THRESH_RST);
		send(CMD_PIXEL, 8'd0, 8'h00, 8'h00, 8'h00, 12'h000, 12'h000);
		send(CMD_PIXEL, 8'd0, 8'hff, 8'hff, 8'hff, 12'hfff, 12'hfff);
		send(CMD_PIXEL, 8'd0, 8'h80, 8'h40, 8'hc0, 12'h005, 12'h003);
		// threshold above 100
		set_regs(7'd5, 7'd127);
		send(CMD_PIXEL, 8'd0, 8'h10, 8'hf0, 8'h08, 12'h7, 12'h6);
		send(CMD_PIXEL, 8'd0, 8'hff, 8'h00, 8'hff, 12'h2, 12'h1);
		// single entry, no feedback
		set_regs(7'd0, 7'd0);
		send(CMD_PIXEL, 8'd0, 8'h55, 8'haa, 8'h33, 12'h0, 12'h7);
		send(CMD_WRITE, 8'd0, 8'h7f, 8'h80, 8'h01, 12'h0, 12'h0);
		send(CMD_PIXEL, 8'd0, 8'h00, 8'hff, 8'h00, 12'h7, 12'h0);
		// two entries, full feedback: large error drives attempts negative
		set_regs(7'd1, 7'd100);
		send(CMD_PIXEL, 8'd0, 8'h01, 8'h02, 8'h03, 12'h3, 12'h4);
		send(CMD_PIXEL, 8'd0, 8'hfe, 8'h80, 8'h7f, 12'h4, 12'h3);
		set_regs(7'd4, 7'd1);
		send(CMD_PIXEL, 8'd0, 8'h20, 8'h30, 8'h40, 12'h1, 12'h5);

		for (int p = 0; p < 5; p++) begin
			case ($urandom_range(0, 3))
				0: thr = 7'd0;
				1: thr = 7'd100;
				2: thr = 7'd127;
				default: thr = 7'($urandom_range(0, 127));
			endcase
			set_regs((p == 2) ? 7'd5 : 7'($urandom_range(0, 3)), thr);
			quiet = (p == 4);
			n = (p == 2) ? 5 : 14;
			for (int i = 0; i < n; i++) begin
				if (p == 1 && i == 12) begin
					in_valid <= 0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				if ($urandom_range(0, 4) == 0)
					send(CMD_WRITE, 8'($urandom_range(0, 255)), rand_chan(), rand_chan(),
						rand_chan(), 12'($urandom_range(0, 4095)),
						12'($urandom_range(0, 4095)));
				else
					rand_pixel();
			end
		end

		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
